### rtl/gn3d_pkg.sv
// shared constants, types and helpers for the gradient noise pipeline
package gn3d_pkg;

  localparam int HASH_BITS       = 8;
  localparam int HASH_SIZE       = 1 << HASH_BITS;
  localparam int COORD_FRAC_BITS = 16;
  localparam int GRAD_FRAC_BITS  = 14;
  localparam int OUT_FRAC_BITS   = 14;

  localparam int COORD_W     = 32;
  localparam int GRAD_W      = 16;
  localparam int OUT_W       = 16;
  localparam int IDX_W       = 8;
  localparam int CELL_W      = COORD_W - COORD_FRAC_BITS + 1;
  localparam int FRAC_W      = COORD_FRAC_BITS;
  localparam int OFF_W       = FRAC_W + 1;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int P_W         = FRAC_W + 4;
  localparam int PROD_W      = GRAD_W + OFF_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int DIFF_W      = DOT_W + 1;
  localparam int BPROD_W     = DIFF_W + WGT_W + 1;
  localparam int RND_SHIFT   = COORD_FRAC_BITS + GRAD_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RES_W       = DOT_W + 1 - RND_SHIFT;
  localparam int GRAD_WORD_W = 3 * GRAD_W;
  localparam int CORNERS     = 8;
  localparam int AXES        = 3;
  localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN     = -(1 << (OUT_W - 1));

  typedef enum logic [1:0] {
    CMD_LOAD_PERM = 2'd0,
    CMD_LOAD_GRAD = 2'd1,
    CMD_EVAL      = 2'd2
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic eval;
    logic perm_we;
    logic grad_we;
  } hash_ctl_t;

  // low hash bits of the magnitude of a cell coordinate
  function automatic logic [HASH_BITS-1:0] abs_low(input logic signed [CELL_W-1:0] n);
    logic [CELL_W-1:0] neg;
    neg = -n;
    return n[CELL_W-1] ? neg[HASH_BITS-1:0] : n[HASH_BITS-1:0];
  endfunction

endpackage

### rtl/gn3d_ram.sv
// generic table memory, one write port and two registered read ports
module gn3d_ram import gn3d_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [HASH_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 ren,
  input  logic [HASH_BITS-1:0] raddr_a,
  input  logic [HASH_BITS-1:0] raddr_b,
  output logic [WIDTH-1:0]     rdata_a,
  output logic [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [HASH_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/gn3d_hash.sv
// corner hashing through replicated permutation tables and gradient fetch
module gn3d_hash import gn3d_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hash_ctl_t                            ctl,
  input  logic [IDX_W-1:0]                     table_index,
  input  logic [IDX_W-1:0]                     perm_value,
  input  logic [GRAD_WORD_W-1:0]               grad_word,
  input  logic signed [COORD_W-1:0]            point_y,
  input  logic signed [COORD_W-1:0]            point_z,
  input  logic signed [COORD_W-1:0]            point_x,
  output logic                                 busy,
  output logic                                 grad_v,
  output logic [CORNERS-1:0][GRAD_WORD_W-1:0]  grad
);

  logic [HASH_BITS-1:0] widx;
  logic signed [CELL_W-1:0] cy0, cz0, cx0, cy1, cz1, cx1;

  logic [1:0][HASH_BITS-1:0] ay_r, az_r, ax_r, az2_r, ax2_r, ax3_r;
  logic [1:0][HASH_BITS-1:0] hy;
  logic [3:0][HASH_BITS-1:0] hyz;
  logic [CORNERS-1:0][HASH_BITS-1:0] hc;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign widx = table_index[HASH_BITS-1:0];

  // cell corners, high corner exact without wrap
  assign cy0 = CELL_W'(point_y >>> COORD_FRAC_BITS);
  assign cz0 = CELL_W'(point_z >>> COORD_FRAC_BITS);
  assign cx0 = CELL_W'(point_x >>> COORD_FRAC_BITS);
  assign cy1 = cy0 + CELL_W'(1);
  assign cz1 = cz0 + CELL_W'(1);
  assign cx1 = cx0 + CELL_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ay_r  <= {abs_low(cy1), abs_low(cy0)};
      az_r  <= {abs_low(cz1), abs_low(cz0)};
      ax_r  <= {abs_low(cx1), abs_low(cx0)};
      az2_r <= az_r;
      ax2_r <= ax_r;
      ax3_r <= ax2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (ctl.adv) begin
      v1_r <= ctl.eval;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // first level, y corners
  gn3d_ram #(.WIDTH(HASH_BITS)) u_perm_y (
    .clk(clk), .we(ctl.perm_we), .waddr(widx), .wdata(perm_value[HASH_BITS-1:0]),
    .ren(ctl.adv), .raddr_a(ay_r[0]), .raddr_b(ay_r[1]),
    .rdata_a(hy[0]), .rdata_b(hy[1])
  );

  // second level, one copy per z corner
  for (genvar k = 0; k < 2; k++) begin : g_perm_z
    gn3d_ram #(.WIDTH(HASH_BITS)) u_perm (
      .clk(clk), .we(ctl.perm_we), .waddr(widx), .wdata(perm_value[HASH_BITS-1:0]),
      .ren(ctl.adv),
      .raddr_a(hy[0] + az2_r[k]), .raddr_b(hy[1] + az2_r[k]),
      .rdata_a(hyz[2*k]), .rdata_b(hyz[2*k+1])
    );
  end

  // third level, eight corners over four copies
  for (genvar q = 0; q < CORNERS / 2; q++) begin : g_perm_x
    gn3d_ram #(.WIDTH(HASH_BITS)) u_perm (
      .clk(clk), .we(ctl.perm_we), .waddr(widx), .wdata(perm_value[HASH_BITS-1:0]),
      .ren(ctl.adv),
      .raddr_a(hyz[(2*q) % 4] + ax3_r[(2*q) / 4]),
      .raddr_b(hyz[(2*q+1) % 4] + ax3_r[(2*q+1) / 4]),
      .rdata_a(hc[2*q]), .rdata_b(hc[2*q+1])
    );
  end

  for (genvar q = 0; q < CORNERS / 2; q++) begin : g_grad
    gn3d_ram #(.WIDTH(GRAD_WORD_W)) u_grad (
      .clk(clk), .we(ctl.grad_we), .waddr(widx), .wdata(grad_word),
      .ren(ctl.adv), .raddr_a(hc[2*q]), .raddr_b(hc[2*q+1]),
      .rdata_a(grad[2*q]), .rdata_b(grad[2*q+1])
    );
  end

  assign busy   = v1_r | v2_r | v3_r | v4_r;
  assign grad_v = v5_r;

endmodule

### rtl/gn3d_fade.sv
// quintic fade weights for the three axes
module gn3d_fade import gn3d_pkg::*; (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [AXES-1:0][FRAC_W-1:0]   t_in,
  output logic [AXES-1:0][FRAC_W-1:0]   t_out,
  output logic [AXES-1:0][WGT_W-1:0]    w_out
);

  logic [AXES-1:0][FRAC_W-1:0]     t1_r, t2_r, t3_r, t4_r;
  logic [AXES-1:0][2*FRAC_W-1:0]   tsq1_r, cub3_r;
  logic [AXES-1:0][FRAC_W-1:0]     sq2_r;
  logic [AXES-1:0][P_W-1:0]        p2_r, p3_r;
  logic [AXES-1:0][FRAC_W+P_W-1:0] f4_r;
  logic [AXES-1:0][P_W-1:0]        p_nxt;
  logic [AXES-1:0][2*FRAC_W+2:0]   six_sq;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      six_sq[a] = ((2*FRAC_W+3)'(tsq1_r[a]) << 2) + ((2*FRAC_W+3)'(tsq1_r[a]) << 1);
      p_nxt[a]  = (P_W'(10) << FRAC_W)
                - ((P_W'(t1_r[a]) << 4) - P_W'(t1_r[a]))
                + P_W'(six_sq[a] >> FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        t1_r[a]   <= t_in[a];
        tsq1_r[a] <= t_in[a] * t_in[a];
        t2_r[a]   <= t1_r[a];
        sq2_r[a]  <= tsq1_r[a][2*FRAC_W-1:FRAC_W];
        p2_r[a]   <= p_nxt[a];
        t3_r[a]   <= t2_r[a];
        cub3_r[a] <= sq2_r[a] * t2_r[a];
        p3_r[a]   <= p2_r[a];
        t4_r[a]   <= t3_r[a];
        f4_r[a]   <= cub3_r[a][2*FRAC_W-1:FRAC_W] * p3_r[a];
        t_out[a]  <= t4_r[a];
        w_out[a]  <= f4_r[a][FRAC_W+WGT_W-1:FRAC_W];
      end
    end
  end

endmodule

### rtl/gn3d_blend.sv
// corner dot products, trilinear fade blend, rounding and saturation
module gn3d_blend import gn3d_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_v,
  input  logic [CORNERS-1:0][GRAD_WORD_W-1:0] grad,
  input  logic [AXES-1:0][FRAC_W-1:0]         t,
  input  logic [AXES-1:0][WGT_W-1:0]          w,
  output logic                                res_v,
  output logic [OUT_W-1:0]                    res
);

  logic v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r, v13_r, v14_r;
  logic [AXES-1:0][WGT_W-1:0] w6_r, w7_r, w8_r, w9_r, w10_r, w11_r;

  logic signed [PROD_W-1:0]  pr6_r [CORNERS][AXES];
  logic signed [DOT_W-1:0]   dot7_r [CORNERS];
  logic signed [BPROD_W-1:0] by8_r [4];
  logic signed [DOT_W-1:0]   ay8_r [4];
  logic signed [DOT_W-1:0]   iy9_r [4];
  logic signed [BPROD_W-1:0] bz10_r [2];
  logic signed [DOT_W-1:0]   az10_r [2];
  logic signed [DOT_W-1:0]   iz11_r [2];
  logic signed [BPROD_W-1:0] bx12_r;
  logic signed [DOT_W-1:0]   ax12_r;
  logic signed [DOT_W-1:0]   v13_val_r;
  logic [OUT_W-1:0]          res14_r;

  logic signed [BPROD_W-1:0] shy [4];
  logic signed [BPROD_W-1:0] shz [2];
  logic signed [BPROD_W-1:0] shx;
  logic signed [DOT_W:0]     rnd;
  logic signed [RES_W-1:0]   rsh;
  logic [OUT_W-1:0]          sat;

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      shy[q] = by8_r[q] >>> COORD_FRAC_BITS;
    end
    for (int l = 0; l < 2; l++) begin
      shz[l] = bz10_r[l] >>> COORD_FRAC_BITS;
    end
    shx = bx12_r >>> COORD_FRAC_BITS;
    rnd = (DOT_W+1)'(v13_val_r) + ((DOT_W+1)'(1) <<< (RND_SHIFT - 1));
    rsh = RES_W'(rnd >>> RND_SHIFT);
    if (rsh > OUT_MAX) begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (rsh < OUT_MIN) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = rsh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // offsets: low corner t, high corner t - 1 (high bit set)
      for (int c = 0; c < CORNERS; c++) begin
        for (int a = 0; a < AXES; a++) begin
          pr6_r[c][a] <= $signed(grad[c][GRAD_WORD_W-1-a*GRAD_W -: GRAD_W])
                       * $signed({c[a], t[a]});
        end
        dot7_r[c] <= DOT_W'(pr6_r[c][0]) + DOT_W'(pr6_r[c][1]) + DOT_W'(pr6_r[c][2]);
      end
      for (int q = 0; q < 4; q++) begin
        by8_r[q] <= (DIFF_W'(dot7_r[2*q+1]) - DIFF_W'(dot7_r[2*q]))
                  * $signed({1'b0, w7_r[0]});
        ay8_r[q] <= dot7_r[2*q];
        iy9_r[q] <= ay8_r[q] + shy[q][DOT_W-1:0];
      end
      for (int l = 0; l < 2; l++) begin
        bz10_r[l] <= (DIFF_W'(iy9_r[2*l+1]) - DIFF_W'(iy9_r[2*l]))
                   * $signed({1'b0, w9_r[1]});
        az10_r[l] <= iy9_r[2*l];
        iz11_r[l] <= az10_r[l] + shz[l][DOT_W-1:0];
      end
      bx12_r    <= (DIFF_W'(iz11_r[1]) - DIFF_W'(iz11_r[0])) * $signed({1'b0, w11_r[2]});
      ax12_r    <= iz11_r[0];
      v13_val_r <= ax12_r + shx[DOT_W-1:0];
      res14_r   <= sat;
      w6_r  <= w;
      w7_r  <= w6_r;
      w8_r  <= w7_r;
      w9_r  <= w8_r;
      w10_r <= w9_r;
      w11_r <= w10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
    end else if (adv) begin
      v6_r  <= in_v;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
    end
  end

  assign res_v = v14_r;
  assign res   = res14_r;

endmodule

### rtl/gradient_noise_3d_top.sv
// top level of the three-dimensional gradient noise evaluator
//
// Evaluates 3d gradient noise at a Q16.16 point and returns a saturated Q2.14
// value, one word per cycle while the output is not stalled. Command 0 loads
// a permutation entry, command 1 loads a gradient entry (y, z, x in Q1.14),
// command 2 evaluates a point, command 3 is taken and ignored. Loads give no
// result. Evaluation is a 14-stage pipeline: stage 1 floors the coordinates
// and forms corner hash inputs, stages 2 to 4 walk the three permutation
// levels, stage 5 fetches the eight gradients while the fade curves finish in
// parallel, stages 6 and 7 form the corner dot products, stages 8 to 13 blend
// along y, z and x, and stage 14 rounds and saturates. Each table is
// replicated so that every lookup of one level happens in the same cycle,
// giving a sustained rate of one evaluate word per cycle while the output
// does not stall. Loads write all copies at once when accepted; a load is
// held off while an evaluate still sits in stages 1 to 4. A one-entry skid
// buffer after the output register lets the pipeline take new words while a
// result waits. Reading a table entry that was never loaded gives an
// undefined noise value.
module gradient_noise_3d_top import gn3d_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [IDX_W-1:0]           in_table_index,
  input  logic [IDX_W-1:0]           in_perm_value,
  input  logic signed [GRAD_W-1:0]   in_grad_y,
  input  logic signed [GRAD_W-1:0]   in_grad_z,
  input  logic signed [GRAD_W-1:0]   in_grad_x,
  input  logic signed [COORD_W-1:0]  in_point_y,
  input  logic signed [COORD_W-1:0]  in_point_z,
  input  logic signed [COORD_W-1:0]  in_point_x,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    out_noise_value
);

  logic      adv;
  logic      busy;
  logic      accept;
  logic      is_eval, is_load;
  hash_ctl_t ctl;

  logic                                grad_v;
  logic [CORNERS-1:0][GRAD_WORD_W-1:0] grad;
  logic [AXES-1:0][FRAC_W-1:0]         t_in, t5;
  logic [AXES-1:0][WGT_W-1:0]          w5;
  logic                                res_v;
  logic [OUT_W-1:0]                    res;

  logic             out_valid_r, skid_v_r;
  logic [OUT_W-1:0] out_data_r, skid_data_r;
  logic             out_free;

  // whole pipeline moves unless the skid buffer holds a word
  assign adv      = !skid_v_r;
  assign is_eval  = (in_command == CMD_EVAL);
  assign is_load  = (in_command == CMD_LOAD_PERM) || (in_command == CMD_LOAD_GRAD);

  // evaluates need the pipeline to move, loads must not overtake pending reads
  assign in_stall = is_eval ? !adv : (is_load ? busy : 1'b0);
  assign accept   = in_valid && !in_stall;

  assign ctl.adv     = adv;
  assign ctl.eval    = accept && is_eval;
  assign ctl.perm_we = accept && (in_command == CMD_LOAD_PERM);
  assign ctl.grad_we = accept && (in_command == CMD_LOAD_GRAD);

  assign t_in = {in_point_x[FRAC_W-1:0], in_point_z[FRAC_W-1:0], in_point_y[FRAC_W-1:0]};

  gn3d_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .table_index (in_table_index),
    .perm_value  (in_perm_value),
    .grad_word   ({in_grad_y, in_grad_z, in_grad_x}),
    .point_y     (in_point_y),
    .point_z     (in_point_z),
    .point_x     (in_point_x),
    .busy        (busy),
    .grad_v      (grad_v),
    .grad        (grad)
  );

  gn3d_fade u_fade (
    .clk   (clk),
    .adv   (adv),
    .t_in  (t_in),
    .t_out (t5),
    .w_out (w5)
  );

  gn3d_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (grad_v),
    .grad  (grad),
    .t     (t5),
    .w     (w5),
    .res_v (res_v),
    .res   (res)
  );

  // output register with skid: last stage drains on every advance
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (adv) begin
      if (out_free) begin
        out_valid_r <= res_v;
      end else if (res_v) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b1;
      skid_v_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (out_free) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end else if (out_free) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_data_r;

endmodule

### verif/gradient_noise_3d_top_test.sv
// self-checking testbench for the three-dimensional gradient noise evaluator
module gradient_noise_3d_top_test;
  import gn3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // command 3 has no name in the package, the block takes it and drops it
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int STALL_LIMIT = 5000;    // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;     // longer than the pipeline latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_command = '0;
  logic [IDX_W-1:0]          in_table_index = '0;
  logic [IDX_W-1:0]          in_perm_value = '0;
  logic signed [GRAD_W-1:0]  in_grad_y = '0;
  logic signed [GRAD_W-1:0]  in_grad_z = '0;
  logic signed [GRAD_W-1:0]  in_grad_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b1;
  logic signed [OUT_W-1:0]   out_noise_value;

  gradient_noise_3d_top dut (.*);

  always #2 clk = ~clk;

  // shadow copies of the two tables, updated when a load word is accepted
  logic [7:0]         perm_shadow [HASH_SIZE];
  logic signed [15:0] grad_shadow [HASH_SIZE][AXES];

  // expected noise values, oldest first
  logic signed [OUT_W-1:0] noise_expected [$];

  int mismatches = 0;
  int in_idle_pct = 38;
  int out_idle_pct = 38;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  // quintic fade 6t^5-15t^4+10t^3 in Q0.16
  function automatic longint fade_weight(longint t);
    longint one, t2, t3, p;
    one = 64'sd1 <<< COORD_FRAC_BITS;
    t2 = (t * t) >>> COORD_FRAC_BITS;
    t3 = (t2 * t) >>> COORD_FRAC_BITS;
    p = (10 * one * one - 15 * t * one + 6 * t * t) >>> COORD_FRAC_BITS;
    return (t3 * p) >>> COORD_FRAC_BITS;
  endfunction

  function automatic longint lerp_fixed(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> COORD_FRAC_BITS);
  endfunction

  function automatic longint cell_hash_low(longint n);
    longint m;
    m = (n < 0) ? -n : n;
    return m % HASH_SIZE;
  endfunction

  // noise at one point from the shadow tables, Q2.14 saturated
  function automatic logic signed [OUT_W-1:0] noise_at(logic signed [31:0] py,
                                                       logic signed [31:0] pz,
                                                       logic signed [31:0] px);
    longint coord [AXES];
    longint cell_idx [AXES];
    longint frac [AXES];
    longint wgt [AXES];
    longint dot [CORNERS];
    longint one, h, cc, off, i1, i2, i3, i4, i5, i6, v, r;
    one = 64'sd1 <<< COORD_FRAC_BITS;
    coord[0] = py;
    coord[1] = pz;
    coord[2] = px;
    for (int a = 0; a < AXES; a++) begin
      cell_idx[a] = coord[a] >>> COORD_FRAC_BITS;
      frac[a] = coord[a] - (cell_idx[a] <<< COORD_FRAC_BITS);
      wgt[a] = fade_weight(frac[a]);
    end
    // corner k: bit 0 picks the y side, bit 1 z, bit 2 x
    for (int k = 0; k < CORNERS; k++) begin
      h = 0;
      dot[k] = 0;
      for (int a = 0; a < AXES; a++) begin
        cc = cell_idx[a] + ((k >> a) & 1);
        h = perm_shadow[(h + cell_hash_low(cc)) % HASH_SIZE];
      end
      for (int a = 0; a < AXES; a++) begin
        off = ((k >> a) & 1) ? frac[a] - one : frac[a];
        dot[k] += longint'(grad_shadow[h][a]) * off;
      end
    end
    i1 = lerp_fixed(dot[0], dot[1], wgt[0]);
    i2 = lerp_fixed(dot[2], dot[3], wgt[0]);
    i3 = lerp_fixed(dot[4], dot[5], wgt[0]);
    i4 = lerp_fixed(dot[6], dot[7], wgt[0]);
    i5 = lerp_fixed(i1, i2, wgt[1]);
    i6 = lerp_fixed(i3, i4, wgt[1]);
    v = lerp_fixed(i5, i6, wgt[2]);
    r = (v + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  // input side: update shadow tables or queue the expected noise value
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      case (in_command)
        CMD_LOAD_PERM: perm_shadow[in_table_index] <= in_perm_value;
        CMD_LOAD_GRAD: begin
          grad_shadow[in_table_index][0] <= in_grad_y;
          grad_shadow[in_table_index][1] <= in_grad_z;
          grad_shadow[in_table_index][2] <= in_grad_x;
        end
        CMD_EVAL: noise_expected.push_back(noise_at(in_point_y, in_point_z, in_point_x));
        default: ;
      endcase
    end
  end

  // result side: compare every accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: noise %0d", out_noise_value);
      end else begin
        if (out_noise_value !== noise_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d, got %0d",
                     noise_expected[0], out_noise_value);
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  // receiver stall: random, quiet when the percentage is zero, long hold on request
  always @(posedge clk) begin
    if (hold_request && quiet_cycles == 0) begin
      quiet_cycles <= HOLD_CYCLES;
      hold_request <= 1'b0;
      out_stall <= 1'b1;
    end else if (quiet_cycles > 0) begin
      quiet_cycles <= quiet_cycles - 1;
      out_stall <= (quiet_cycles > 1);
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // watchdog: too long without any handshake means the block hung
  int dead_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      dead_cycles <= 0;
    else if (rst_n) begin
      dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= STALL_LIMIT) begin
        $display("** gradient_noise_3d_top: FAILED **");
        $finish;
      end
    end
  end

  // drive one word and hold it until it is taken; random idle cycles first
  task automatic send_word(logic [1:0] cmd, logic [7:0] idx, logic [7:0] pval,
                           logic [15:0] gy, logic [15:0] gz, logic [15:0] gx,
                           logic [31:0] py, logic [31:0] pz, logic [31:0] px);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_table_index <= idx;
    in_perm_value <= pval;
    in_grad_y <= gy;
    in_grad_z <= gz;
    in_grad_x <= gx;
    in_point_y <= py;
    in_point_z <= pz;
    in_point_x <= px;
    do @(posedge clk); while (in_stall);
  endtask

  // evaluate word, unused fields random so every bit toggles
  task automatic send_point(logic [31:0] py, logic [31:0] pz, logic [31:0] px);
    send_word(CMD_EVAL, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), py, pz, px);
  endtask

  task automatic send_perm(logic [7:0] idx, logic [7:0] pval);
    send_word(CMD_LOAD_PERM, idx, pval, 16'($urandom), 16'($urandom), 16'($urandom),
              $urandom, $urandom, $urandom);
  endtask

  task automatic send_grad(logic [7:0] idx, logic [15:0] gy, logic [15:0] gz,
                           logic [15:0] gx);
    send_word(CMD_LOAD_GRAD, idx, 8'($urandom), gy, gz, gx, $urandom, $urandom, $urandom);
  endtask

  // gradient component, mostly inside the Q1.14 range, sometimes any pattern
  function automatic logic [15:0] rand_grad();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // point: full-range random, near the origin with random or edge fractions, or near the extremes
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = {16'($urandom_range(8) - 4), 16'($urandom)};
      2: c = {16'($urandom_range(8) - 4), ($urandom_range(1) ? 16'hffff : 16'h0000)};
      default: c = {($urandom_range(1) ? 16'h7fff : 16'h8000), 16'($urandom)};
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // every entry of both tables is written before the first evaluate
  task automatic test_table_fill();
    for (int i = 0; i < HASH_SIZE; i++)
      send_perm(8'(i), 8'($urandom));
    for (int i = 0; i < HASH_SIZE; i++) begin
      case (i)
        0: send_grad(8'(i), 16'sd16384, 16'sd16384, 16'sd16384);
        1: send_grad(8'(i), -16'sd16384, -16'sd16384, -16'sd16384);
        2: send_grad(8'(i), 16'h7fff, 16'h8000, 16'h7fff);   // outside the stated range
        3: send_grad(8'(i), 16'h8000, 16'h8000, 16'h8000);
        default: send_grad(8'(i), rand_grad(), rand_grad(), rand_grad());
      endcase
    end
  endtask

  // extremes of the coordinates, integer points, ignored command, reload
  task automatic test_directed();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_point(32'h00010000, 32'hffff0000, 32'h00020000);
    send_point(32'h00008000, 32'h00008000, 32'h00008000);
    send_point(32'h0000ffff, 32'hffff0001, 32'h7fff8000);
    send_point(32'h80000000, 32'h7fffffff, 32'h00000000);
    send_word(CMD_IGNORED, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), $urandom, $urandom, $urandom);
    send_point(32'h12345678, 32'h9abcdef0, 32'h0fedcba9);
    // overwrite entries straight after an evaluate, then read them back
    send_perm(8'h00, 8'hff);
    send_perm(8'hff, 8'h00);
    send_grad(8'hff, 16'sd16384, -16'sd16384, 16'h0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'hffffffff, 32'h00000000, 32'hffffffff);
    wait_drained();
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_point(rand_coord(), rand_coord(), rand_coord());
    else if (pick < 82)
      send_perm(8'($urandom), 8'($urandom));
    else if (pick < 95)
      send_grad(8'($urandom), rand_grad(), rand_grad(), rand_grad());
    else
      send_word(CMD_IGNORED, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), $urandom, $urandom, $urandom);
  endtask

  // mixed random traffic with a stretch of full throughput in the middle
  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (n == count / 3 + 300) begin
        in_idle_pct = 38;
        out_idle_pct = 38;
      end
      random_word();
    end
  endtask

  // receiver holds off while evaluates keep coming until the input stalls
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int n = 0; n < 60; n++)
      send_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(600);
    wait_drained();
    if (mismatches == 0 && noise_expected.size() == 0)
      $display("** gradient_noise_3d_top: PASSED **");
    else
      $display("** gradient_noise_3d_top: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/gn3d_pkg.sv
rtl/gn3d_ram.sv
rtl/gn3d_hash.sv
rtl/gn3d_fade.sv
rtl/gn3d_blend.sv
rtl/gradient_noise_3d_top.sv
verif/gradient_noise_3d_top_test.sv
